FILE: sv/scd_pkg.sv
// ----------------------------------------------------------------------------
// scd_pkg
// Shared widths, reset values, limits and register indexes of the shot-cut
// detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package scd_pkg;

	localparam int MAX_DIM_DEF = 4096;

	localparam int PIX_W      = 8;
	localparam int DIM_CFG_W  = 13;
	localparam int THR_W      = 10;
	localparam int RATE_W     = 16;
	localparam int SCORE_W    = 10;
	localparam int FRAME_W    = 32;
	localparam int SHOT_W     = 16;
	localparam int MS_W       = 32;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	localparam logic [DIM_CFG_W-1:0] WIDTH_RST  = 13'd640;
	localparam logic [DIM_CFG_W-1:0] HEIGHT_RST = 13'd480;
	localparam logic [THR_W-1:0]     THR_RST    = 10'd60;
	localparam logic [RATE_W-1:0]    RATE_RST   = 16'd7680;

	localparam int SCORE_MAX = 765;
	localparam int MEAN_MAX  = 255;
	localparam int MS_PER_S  = 1000;
	localparam int RATE_FRAC = 8;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WIDTH,
		CFG_HEIGHT,
		CFG_THRESHOLD,
		CFG_RATE
	} cfg_idx_t;

endpackage

FILE: sv/shot_cut_detector_top.sv
// ----------------------------------------------------------------------------
// shot_cut_detector_top
// Scene-cut detector by frame difference. Each input beat is a pixel pair:
// the current RGB pixel and the co-located pixel of the previous frame, in
// raster order. At the last pixel of a frame the sums are divided by the
// pixel count; from the third frame on one result beat per frame carries
// the motion score, channel means, cut flag and shot bookkeeping.
// Configuration is written through cfg_valid/cfg_ready (always ready),
// index 0 width, 1 height, 2 threshold, 3 frame rate in Q8; write it only
// while the block is idle. Pixels are taken at one per cycle. After the
// last pixel of a frame in_stall stays high while one shared restoring
// divider (W = 50 quotient bits at the defaults) works through score,
// three means and the millisecond figures, the closed-shot one only
// when a cut is found. A result waits in an output
// register while out_stall is high; pixels of the next frame are still
// taken meanwhile, and the block only holds at the end of that next frame.
// Reset clears all state and loads the default configuration.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shot_cut_detector_top import scd_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [PIX_W-1:0]      cur_red,
	input  logic [PIX_W-1:0]      cur_green,
	input  logic [PIX_W-1:0]      cur_blue,
	input  logic [PIX_W-1:0]      old_red,
	input  logic [PIX_W-1:0]      old_green,
	input  logic [PIX_W-1:0]      old_blue,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [FRAME_W-1:0]    frame_index,
	output logic [SCORE_W-1:0]    motion_score,
	output logic [PIX_W-1:0]      mean_red,
	output logic [PIX_W-1:0]      mean_green,
	output logic [PIX_W-1:0]      mean_blue,
	output logic                  cut_found,
	output logic [SHOT_W-1:0]     shot_number,
	output logic [FRAME_W-1:0]    shot_start_frame,
	output logic [MS_W-1:0]       shot_start_ms,
	output logic [FRAME_W-1:0]    closed_shot_frames,
	output logic [MS_W-1:0]       closed_shot_ms,
	input  logic                  cfg_valid,
	output logic                  cfg_ready,
	input  logic [CFG_IDX_W-1:0]  cfg_index,
	input  logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int CNT_W  = 2 * DIM_W;
	localparam int DIFF_W = CNT_W + SCORE_W;
	localparam int SUM_W  = CNT_W + PIX_W;
	localparam int PROD_W = FRAME_W + $clog2(MS_PER_S);
	localparam int MSD_W  = PROD_W + RATE_FRAC;
	localparam int DVD_W  = (MSD_W > DIFF_W) ? MSD_W : DIFF_W;
	localparam int DVS_W  = (CNT_W > RATE_W) ? CNT_W : RATE_W;

	typedef enum logic [3:0] {
		S_IDLE,
		S_DIV_SCORE,
		S_DIV_RED,
		S_DIV_GREEN,
		S_DIV_BLUE,
		S_DECIDE,
		S_MUL_CLOSED,
		S_DIV_CLOSED,
		S_MUL_START,
		S_DIV_START,
		S_EMIT
	} state_t;

	state_t state_q;

	logic [DIM_CFG_W-1:0] width_q;
	logic [DIM_CFG_W-1:0] height_q;
	logic [THR_W-1:0]     thr_q;
	logic [RATE_W-1:0]    rate_q;

	logic              start_q;
	logic [FRAME_W-1:0] frames_q;
	logic [SCORE_W-1:0] last_score_q;
	logic [SHOT_W-1:0]  shot_id_q;
	logic [FRAME_W-1:0] shot_start_q;
	logic [CNT_W-1:0]   total_q;
	logic [SCORE_W-1:0] score_q;
	logic [PIX_W-1:0]   mean_r_q;
	logic [PIX_W-1:0]   mean_g_q;
	logic [PIX_W-1:0]   mean_b_q;
	logic               cut_q;
	logic [FRAME_W-1:0] closed_frames_q;
	logic [MS_W-1:0]    closed_ms_q;
	logic [MS_W-1:0]    start_ms_q;
	logic [PROD_W-1:0]  prod_q;

	logic               out_valid_q;
	logic [FRAME_W-1:0] o_frame_q;
	logic [SCORE_W-1:0] o_score_q;
	logic [PIX_W-1:0]   o_red_q;
	logic [PIX_W-1:0]   o_green_q;
	logic [PIX_W-1:0]   o_blue_q;
	logic               o_cut_q;
	logic [SHOT_W-1:0]  o_shot_q;
	logic [FRAME_W-1:0] o_start_q;
	logic [MS_W-1:0]    o_start_ms_q;
	logic [FRAME_W-1:0] o_closed_q;
	logic [MS_W-1:0]    o_closed_ms_q;

	logic               in_accept;
	logic               frame_end;
	logic               early;
	logic               emit_go;
	logic               acc_clear;
	logic [CNT_W-1:0]   total;
	logic [FRAME_W-1:0] frames_next;
	logic [DIFF_W-1:0]  diff_sum;
	logic [SUM_W-1:0]   red_sum;
	logic [SUM_W-1:0]   green_sum;
	logic [SUM_W-1:0]   blue_sum;
	logic [RATE_W-1:0]  rate_eff;
	logic [DVD_W-1:0]   dvd;
	logic [DVS_W-1:0]   dvs;
	logic               div_done;
	logic [DVD_W-1:0]   quot;
	logic [SCORE_W-1:0] delta;
	logic               cut;
	logic [SCORE_W-1:0] quot_score;
	logic [PIX_W-1:0]   quot_mean;
	logic [MS_W-1:0]    quot_ms;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_CFG_W-1:0] d);
		if (d == '0) begin
			return DIM_W'(1);
		end
		if (32'(d) > MAX_DIM) begin
			return DIM_W'(MAX_DIM);
		end
		return DIM_W'(d);
	endfunction

	// Configuration registers.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RST;
			height_q <= HEIGHT_RST;
			thr_q    <= THR_RST;
			rate_q   <= RATE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_idx_t'(cfg_index))
				CFG_WIDTH:     width_q  <= cfg_data[DIM_CFG_W-1:0];
				CFG_HEIGHT:    height_q <= cfg_data[DIM_CFG_W-1:0];
				CFG_THRESHOLD: thr_q    <= cfg_data[THR_W-1:0];
				CFG_RATE:      rate_q   <= cfg_data[RATE_W-1:0];
				default: ;
			endcase
		end
	end

	assign total = CNT_W'(clamp_dim(width_q)) * CNT_W'(clamp_dim(height_q));

	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && !in_stall;

	assign frames_next = (frames_q == '1) ? frames_q : frames_q + 1'b1;
	assign early       = (frames_next <= FRAME_W'(2));
	assign emit_go     = (state_q == S_EMIT) && (!out_valid_q || !out_stall);
	assign acc_clear   = (frame_end && early) || emit_go;

	scd_accum #(
		.MAX_DIM (MAX_DIM)
	) u_accum (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (in_accept),
		.clear     (acc_clear),
		.cur_red   (cur_red),
		.cur_green (cur_green),
		.cur_blue  (cur_blue),
		.old_red   (old_red),
		.old_green (old_green),
		.old_blue  (old_blue),
		.total     (total),
		.frame_end (frame_end),
		.diff_sum  (diff_sum),
		.red_sum   (red_sum),
		.green_sum (green_sum),
		.blue_sum  (blue_sum)
	);

	assign rate_eff = (rate_q == '0) ? RATE_W'(1) : rate_q;

	always_comb begin
		dvd = '0;
		dvs = DVS_W'(1);
		case (state_q)
			S_DIV_SCORE: begin
				dvd = DVD_W'(diff_sum);
				dvs = DVS_W'(total_q);
			end
			S_DIV_RED: begin
				dvd = DVD_W'(red_sum);
				dvs = DVS_W'(total_q);
			end
			S_DIV_GREEN: begin
				dvd = DVD_W'(green_sum);
				dvs = DVS_W'(total_q);
			end
			S_DIV_BLUE: begin
				dvd = DVD_W'(blue_sum);
				dvs = DVS_W'(total_q);
			end
			S_DIV_CLOSED, S_DIV_START: begin
				// Frames times 1000 times 256, over the Q8 frame rate.
				dvd = DVD_W'({prod_q, {RATE_FRAC{1'b0}}});
				dvs = DVS_W'(rate_eff);
			end
			default: ;
		endcase
	end

	scd_div #(
		.DVD_W (DVD_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start_q),
		.dividend (dvd),
		.divisor  (dvs),
		.done     (div_done),
		.quotient (quot)
	);

	assign quot_score = (quot > DVD_W'(SCORE_MAX)) ? SCORE_W'(SCORE_MAX) : quot[SCORE_W-1:0];
	assign quot_mean  = (quot > DVD_W'(MEAN_MAX)) ? PIX_W'(MEAN_MAX) : quot[PIX_W-1:0];
	assign quot_ms    = (|quot[DVD_W-1:MS_W]) ? '1 : quot[MS_W-1:0];

	assign delta = (score_q > last_score_q) ? score_q - last_score_q : last_score_q - score_q;
	assign cut   = (delta > thr_q) && (score_q > thr_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= S_IDLE;
			start_q         <= 1'b0;
			frames_q        <= '0;
			last_score_q    <= '0;
			shot_id_q       <= '0;
			shot_start_q    <= '0;
			total_q         <= '0;
			score_q         <= '0;
			mean_r_q        <= '0;
			mean_g_q        <= '0;
			mean_b_q        <= '0;
			cut_q           <= 1'b0;
			closed_frames_q <= '0;
			closed_ms_q     <= '0;
			start_ms_q      <= '0;
			prod_q          <= '0;
			out_valid_q     <= 1'b0;
			o_frame_q       <= '0;
			o_score_q       <= '0;
			o_red_q         <= '0;
			o_green_q       <= '0;
			o_blue_q        <= '0;
			o_cut_q         <= 1'b0;
			o_shot_q        <= '0;
			o_start_q       <= '0;
			o_start_ms_q    <= '0;
			o_closed_q      <= '0;
			o_closed_ms_q   <= '0;
		end else begin
			start_q <= 1'b0;
			if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (frame_end) begin
						frames_q <= frames_next;
						if (!early) begin
							total_q <= total;
							start_q <= 1'b1;
							state_q <= S_DIV_SCORE;
						end
					end
				end
				S_DIV_SCORE: begin
					if (div_done) begin
						score_q <= quot_score;
						start_q <= 1'b1;
						state_q <= S_DIV_RED;
					end
				end
				S_DIV_RED: begin
					if (div_done) begin
						mean_r_q <= quot_mean;
						start_q  <= 1'b1;
						state_q  <= S_DIV_GREEN;
					end
				end
				S_DIV_GREEN: begin
					if (div_done) begin
						mean_g_q <= quot_mean;
						start_q  <= 1'b1;
						state_q  <= S_DIV_BLUE;
					end
				end
				S_DIV_BLUE: begin
					if (div_done) begin
						mean_b_q <= quot_mean;
						state_q  <= S_DECIDE;
					end
				end
				S_DECIDE: begin
					last_score_q <= score_q;
					cut_q        <= cut;
					if (cut) begin
						closed_frames_q <= frames_q - shot_start_q;
						shot_start_q    <= frames_q;
						if (shot_id_q != '1) begin
							shot_id_q <= shot_id_q + 1'b1;
						end
						state_q <= S_MUL_CLOSED;
					end else begin
						closed_frames_q <= '0;
						closed_ms_q     <= '0;
						state_q         <= S_MUL_START;
					end
				end
				S_MUL_CLOSED: begin
					prod_q  <= PROD_W'(closed_frames_q) * PROD_W'(MS_PER_S);
					start_q <= 1'b1;
					state_q <= S_DIV_CLOSED;
				end
				S_DIV_CLOSED: begin
					if (div_done) begin
						closed_ms_q <= quot_ms;
						state_q     <= S_MUL_START;
					end
				end
				S_MUL_START: begin
					prod_q  <= PROD_W'(shot_start_q) * PROD_W'(MS_PER_S);
					start_q <= 1'b1;
					state_q <= S_DIV_START;
				end
				S_DIV_START: begin
					if (div_done) begin
						start_ms_q <= quot_ms;
						state_q    <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (emit_go) begin
						out_valid_q   <= 1'b1;
						o_frame_q     <= frames_q;
						o_score_q     <= score_q;
						o_red_q       <= mean_r_q;
						o_green_q     <= mean_g_q;
						o_blue_q      <= mean_b_q;
						o_cut_q       <= cut_q;
						o_shot_q      <= shot_id_q;
						o_start_q     <= shot_start_q;
						o_start_ms_q  <= start_ms_q;
						o_closed_q    <= closed_frames_q;
						o_closed_ms_q <= closed_ms_q;
						state_q       <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid          = out_valid_q;
	assign frame_index        = o_frame_q;
	assign motion_score       = o_score_q;
	assign mean_red           = o_red_q;
	assign mean_green         = o_green_q;
	assign mean_blue          = o_blue_q;
	assign cut_found          = o_cut_q;
	assign shot_number        = o_shot_q;
	assign shot_start_frame   = o_start_q;
	assign shot_start_ms      = o_start_ms_q;
	assign closed_shot_frames = o_closed_q;
	assign closed_shot_ms     = o_closed_ms_q;

endmodule

FILE: sv/scd_div.sv
// ----------------------------------------------------------------------------
// scd_div
// Restoring divider, one quotient bit per cycle. Shared by every division
// of the detector.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_div #(
	parameter int DVD_W = 50,
	parameter int DVS_W = 26,
	localparam int CNT_W = $clog2(DVD_W)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [DVD_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output logic             done,
	output logic [DVD_W-1:0] quotient
);

	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVD_W-1:0] quo_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic [DVS_W:0]   trial;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign trial = {rem_q, quo_q[DVD_W-1]};
	assign ge    = trial >= {1'b0, dvs_q};
	assign diff  = trial - {1'b0, dvs_q};

	// The dividend shifts out of the top of quo_q while quotient bits enter below.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rem_q  <= '0;
			dvs_q  <= '0;
			quo_q  <= '0;
			cnt_q  <= '0;
			busy_q <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				rem_q  <= '0;
				dvs_q  <= divisor;
				quo_q  <= dividend;
				cnt_q  <= '0;
				busy_q <= 1'b1;
			end else if (busy_q) begin
				rem_q <= ge ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
				quo_q <= {quo_q[DVD_W-2:0], ge};
				if (cnt_q == CNT_W'(DVD_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					cnt_q <= cnt_q + 1'b1;
				end
			end
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

endmodule

FILE: sv/scd_accum.sv
// ----------------------------------------------------------------------------
// scd_accum
// Per-frame accumulation of channel differences and channel values, with
// the pixel counter that marks the last pixel of a frame.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_accum import scd_pkg::*; #(
	parameter int MAX_DIM = MAX_DIM_DEF,
	localparam int DIM_W  = $clog2(MAX_DIM + 1),
	localparam int CNT_W  = 2 * DIM_W,
	localparam int DIFF_W = CNT_W + SCORE_W,
	localparam int SUM_W  = CNT_W + PIX_W
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic              clear,
	input  logic [PIX_W-1:0]  cur_red,
	input  logic [PIX_W-1:0]  cur_green,
	input  logic [PIX_W-1:0]  cur_blue,
	input  logic [PIX_W-1:0]  old_red,
	input  logic [PIX_W-1:0]  old_green,
	input  logic [PIX_W-1:0]  old_blue,
	input  logic [CNT_W-1:0]  total,
	output logic              frame_end,
	output logic [DIFF_W-1:0] diff_sum,
	output logic [SUM_W-1:0]  red_sum,
	output logic [SUM_W-1:0]  green_sum,
	output logic [SUM_W-1:0]  blue_sum
);

	logic [DIFF_W-1:0] diff_q;
	logic [SUM_W-1:0]  red_q;
	logic [SUM_W-1:0]  green_q;
	logic [SUM_W-1:0]  blue_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [CNT_W-1:0]  cnt_inc;
	logic [PIX_W-1:0]  d_red;
	logic [PIX_W-1:0]  d_green;
	logic [PIX_W-1:0]  d_blue;

	function automatic logic [PIX_W-1:0] absdiff(input logic [PIX_W-1:0] a,
			input logic [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	assign d_red   = absdiff(cur_red, old_red);
	assign d_green = absdiff(cur_green, old_green);
	assign d_blue  = absdiff(cur_blue, old_blue);

	// The count never passes the largest frame, so it cannot wrap here.
	assign cnt_inc   = cnt_q + 1'b1;
	assign frame_end = accept && (cnt_inc >= total);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			diff_q  <= '0;
			red_q   <= '0;
			green_q <= '0;
			blue_q  <= '0;
			cnt_q   <= '0;
		end else begin
			if (accept) begin
				cnt_q <= frame_end ? '0 : cnt_inc;
			end
			if (clear) begin
				diff_q  <= '0;
				red_q   <= '0;
				green_q <= '0;
				blue_q  <= '0;
			end else if (accept) begin
				diff_q  <= diff_q + DIFF_W'(d_red) + DIFF_W'(d_green) + DIFF_W'(d_blue);
				red_q   <= red_q + SUM_W'(cur_red);
				green_q <= green_q + SUM_W'(cur_green);
				blue_q  <= blue_q + SUM_W'(cur_blue);
			end
		end
	end

	assign diff_sum  = diff_q;
	assign red_sum   = red_q;
	assign green_sum = green_q;
	assign blue_sum  = blue_q;

endmodule

FILE: sv/scd_checker.sv
// ----------------------------------------------------------------------------
// scd_checker
// Port-level checks of the shot-cut detector, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module scd_checker import scd_pkg::*; (
	input logic               clk,
	input logic               arst_n,
	input logic               out_valid,
	input logic               out_stall,
	input logic [FRAME_W-1:0] frame_index,
	input logic [SCORE_W-1:0] motion_score,
	input logic               cut_found,
	input logic [FRAME_W-1:0] shot_start_frame,
	input logic [FRAME_W-1:0] closed_shot_frames,
	input logic [MS_W-1:0]    closed_shot_ms
);

	// A stalled result beat stays put.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(frame_index)
			&& $stable(motion_score) && $stable(cut_found))
		else $error("result beat changed while stalled");

	// A cut opens the new shot at the frame just finished.
	a_cut_opens: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && cut_found |-> shot_start_frame == frame_index)
		else $error("cut did not open a shot at this frame");

	// Without a cut nothing is closed.
	a_no_close: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !cut_found |-> closed_shot_frames == '0 && closed_shot_ms == '0)
		else $error("closed shot reported without a cut");

	// Results start at the third frame and the score is saturated.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> frame_index >= FRAME_W'(3) && motion_score <= SCORE_W'(SCORE_MAX))
		else $error("result frame or score out of range");

endmodule

bind shot_cut_detector_top scd_checker u_scd_checker (.*);

FILE: tb/sv/shot_cut_detector_top_tb.sv
// ----------------------------------------------------------------------------
// shot_cut_detector_top_tb
// Self-checking bench for the shot-cut detector. A short directed table of
// one-pixel frames comes first; a few of its results are typed in, the rest
// are checked against a predictor kept in step with every accepted pixel.
// The bench then walks corner settings: zero and oversize dimensions, zero
// and extreme frame rates, extreme thresholds and an oversize frame that is
// left open. Random phases with small frames and fresh settings follow.
// Settings change only once all pending frame results are in and the divider
// has had time to finish. The sender works in bursts and the receiver stalls
// on a pattern of its own.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module shot_cut_detector_top_tb;
	import scd_pkg::*;

	localparam int DRAIN_CYCLES = 400;
	localparam int RANDOM_PIXELS = 1800;
	localparam longint unsigned RUN_LIMIT_NS = 50_000_000;
	localparam longint unsigned MSEC_Q8 = MS_PER_S * (1 << RATE_FRAC);

	typedef struct packed {
		logic [PIX_W-1:0] cur_red;
		logic [PIX_W-1:0] cur_green;
		logic [PIX_W-1:0] cur_blue;
		logic [PIX_W-1:0] old_red;
		logic [PIX_W-1:0] old_green;
		logic [PIX_W-1:0] old_blue;
	} pixel_t;

	typedef struct packed {
		logic [FRAME_W-1:0] frame_index;
		logic [SCORE_W-1:0] motion_score;
		logic [PIX_W-1:0]   mean_red;
		logic [PIX_W-1:0]   mean_green;
		logic [PIX_W-1:0]   mean_blue;
		logic               cut_found;
		logic [SHOT_W-1:0]  shot_number;
		logic [FRAME_W-1:0] shot_start_frame;
		logic [MS_W-1:0]    shot_start_ms;
		logic [FRAME_W-1:0] closed_shot_frames;
		logic [MS_W-1:0]    closed_shot_ms;
	} frame_result_t;

	typedef struct {
		pixel_t        pix;
		bit            typed;
		frame_result_t want;
	} stim_row_t;

	typedef struct {
		logic [CFG_DATA_W-1:0] width_word;
		logic [CFG_DATA_W-1:0] height_word;
		logic [CFG_DATA_W-1:0] thr_word;
		logic [CFG_DATA_W-1:0] rate_word;
		int unsigned           pixels;
	} phase_cfg_t;

	typedef enum int {SCENE_STILL, SCENE_NOISY, SCENE_INVERT} scene_kind_t;
	typedef enum int {RX_FREE, RX_CHOPPY, RX_HOLD} rx_kind_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [PIX_W-1:0] cur_red = '0;
	logic [PIX_W-1:0] cur_green = '0;
	logic [PIX_W-1:0] cur_blue = '0;
	logic [PIX_W-1:0] old_red = '0;
	logic [PIX_W-1:0] old_green = '0;
	logic [PIX_W-1:0] old_blue = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [FRAME_W-1:0] frame_index;
	logic [SCORE_W-1:0] motion_score;
	logic [PIX_W-1:0] mean_red;
	logic [PIX_W-1:0] mean_green;
	logic [PIX_W-1:0] mean_blue;
	logic cut_found;
	logic [SHOT_W-1:0] shot_number;
	logic [FRAME_W-1:0] shot_start_frame;
	logic [MS_W-1:0] shot_start_ms;
	logic [FRAME_W-1:0] closed_shot_frames;
	logic [MS_W-1:0] closed_shot_ms;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	cfg_idx_t cfg_index = CFG_WIDTH;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	// Predictor copy of the configuration and the frame state.
	bit [DIM_CFG_W-1:0] line_px;
	bit [DIM_CFG_W-1:0] frame_lines;
	bit [THR_W-1:0] cut_level;
	bit [RATE_W-1:0] rate_q8;
	bit [63:0] acc_diff, acc_red, acc_green, acc_blue;
	bit [31:0] px_in_frame;
	bit [SCORE_W-1:0] last_cmp_score;
	bit [FRAME_W-1:0] frame_count;
	bit [SHOT_W-1:0] shot_id;
	bit [FRAME_W-1:0] shot_first;

	frame_result_t pending_frames[$];
	stim_row_t directed_rows[16];
	int unsigned mismatch_count = 0;
	int unsigned burst_left = 0;
	int unsigned random_pixels_sent = 0;
	scene_kind_t scene_mode = SCENE_STILL;
	rx_kind_t rx_mode = RX_FREE;
	int unsigned rx_left = 0;

	shot_cut_detector_top DUT (
		.clk                (clk),
		.arst_n             (arst_n),
		.in_valid           (in_valid),
		.in_stall           (in_stall),
		.cur_red            (cur_red),
		.cur_green          (cur_green),
		.cur_blue           (cur_blue),
		.old_red            (old_red),
		.old_green          (old_green),
		.old_blue           (old_blue),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.frame_index        (frame_index),
		.motion_score       (motion_score),
		.mean_red           (mean_red),
		.mean_green         (mean_green),
		.mean_blue          (mean_blue),
		.cut_found          (cut_found),
		.shot_number        (shot_number),
		.shot_start_frame   (shot_start_frame),
		.shot_start_ms      (shot_start_ms),
		.closed_shot_frames (closed_shot_frames),
		.closed_shot_ms     (closed_shot_ms),
		.cfg_valid          (cfg_valid),
		.cfg_ready          (cfg_ready),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	function automatic bit [31:0] eff_dim(bit [DIM_CFG_W-1:0] d);
		if (d == 0) return 1;
		if (d > MAX_DIM_DEF) return MAX_DIM_DEF;
		return 32'(d);
	endfunction

	function automatic bit [9:0] absd(bit [PIX_W-1:0] a, bit [PIX_W-1:0] b);
		return (a > b) ? a - b : b - a;
	endfunction

	function automatic bit [31:0] capped_quotient(bit [63:0] sum, bit [63:0] n,
			bit [31:0] cap);
		bit [63:0] q;
		q = sum / n;
		return (q > cap) ? cap : q[31:0];
	endfunction

	function automatic bit [MS_W-1:0] frames_to_msec(bit [FRAME_W-1:0] n);
		bit [63:0] rate;
		bit [63:0] q;
		rate = (rate_q8 == 0) ? 64'd1 : 64'(rate_q8);
		q = (64'(n) * MSEC_Q8) / rate;
		return (q > 64'hFFFF_FFFF) ? '1 : q[31:0];
	endfunction

	function automatic void clear_sums();
		acc_diff = 0;
		acc_red = 0;
		acc_green = 0;
		acc_blue = 0;
	endfunction

	function automatic void reset_predictor();
		line_px = WIDTH_RST;
		frame_lines = HEIGHT_RST;
		cut_level = THR_RST;
		rate_q8 = RATE_RST;
		clear_sums();
		px_in_frame = 0;
		last_cmp_score = 0;
		frame_count = 0;
		shot_id = 0;
		shot_first = 0;
	endfunction

	// Appends one expected result beat at the tail of the queue.
	function automatic void queue_result(frame_result_t r);
		pending_frames = {pending_frames, r};
	endfunction

	// Folds one pixel pair into the frame sums; returns 1 with the frame
	// result when this pixel closes a frame that reports.
	function automatic bit score_pixel(input pixel_t p, output frame_result_t r);
		bit [63:0] total;
		bit [31:0] score, delta, closed_n, closed_ms;
		bit cut;
		r = '0;
		acc_diff += absd(p.cur_red, p.old_red) + absd(p.cur_green, p.old_green)
			+ absd(p.cur_blue, p.old_blue);
		acc_red += p.cur_red;
		acc_green += p.cur_green;
		acc_blue += p.cur_blue;
		px_in_frame++;
		total = 64'(eff_dim(line_px)) * 64'(eff_dim(frame_lines));
		if (64'(px_in_frame) < total) return 0;
		px_in_frame = 0;
		if (frame_count != '1) frame_count++;
		if (frame_count <= 2) begin
			clear_sums();
			return 0;
		end
		score = capped_quotient(acc_diff, total, SCORE_MAX);
		r.mean_red = PIX_W'(capped_quotient(acc_red, total, MEAN_MAX));
		r.mean_green = PIX_W'(capped_quotient(acc_green, total, MEAN_MAX));
		r.mean_blue = PIX_W'(capped_quotient(acc_blue, total, MEAN_MAX));
		clear_sums();
		delta = (score > last_cmp_score) ? score - last_cmp_score : last_cmp_score - score;
		last_cmp_score = SCORE_W'(score);
		cut = (delta > cut_level) && (score > cut_level);
		closed_n = 0;
		closed_ms = 0;
		if (cut) begin
			closed_n = frame_count - shot_first;
			closed_ms = frames_to_msec(closed_n);
			if (shot_id != '1) shot_id++;
			shot_first = frame_count;
		end
		r.frame_index = frame_count;
		r.motion_score = SCORE_W'(score);
		r.cut_found = cut;
		r.shot_number = shot_id;
		r.shot_start_frame = shot_first;
		r.shot_start_ms = frames_to_msec(shot_first);
		r.closed_shot_frames = closed_n;
		r.closed_shot_ms = closed_ms;
		return 1;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus
	// ------------------------------------------------------------------
	function automatic pixel_t next_pixel();
		pixel_t p;
		if ($urandom_range(0, 11) == 0) scene_mode = scene_kind_t'($urandom_range(0, 2));
		p.old_red = 8'($urandom);
		p.old_green = 8'($urandom);
		p.old_blue = 8'($urandom);
		case (scene_mode)
			SCENE_STILL: begin
				p.cur_red = p.old_red ^ 8'($urandom_range(0, 3));
				p.cur_green = p.old_green ^ 8'($urandom_range(0, 3));
				p.cur_blue = p.old_blue ^ 8'($urandom_range(0, 3));
			end
			SCENE_NOISY: begin
				p.cur_red = 8'($urandom);
				p.cur_green = 8'($urandom);
				p.cur_blue = 8'($urandom);
			end
			default: begin
				p.cur_red = ~p.old_red;
				p.cur_green = ~p.old_green;
				p.cur_blue = ~p.old_blue;
			end
		endcase
		return p;
	endfunction

	task automatic send_pixel(pixel_t p, bit typed, frame_result_t want);
		frame_result_t r;
		int unsigned gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 16);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 32);
		end
		burst_left--;
		in_valid <= 1'b1;
		cur_red <= p.cur_red;
		cur_green <= p.cur_green;
		cur_blue <= p.cur_blue;
		old_red <= p.old_red;
		old_green <= p.old_green;
		old_blue <= p.old_blue;
		do @(negedge clk); while (in_stall);
		@(posedge clk);
		if (score_pixel(p, r)) queue_result(typed ? want : r);
	endtask

	task automatic write_reg(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(negedge clk); while (!cfg_ready);
		@(posedge clk);
		case (idx)
			CFG_WIDTH: line_px = data[DIM_CFG_W-1:0];
			CFG_HEIGHT: frame_lines = data[DIM_CFG_W-1:0];
			CFG_THRESHOLD: cut_level = data[THR_W-1:0];
			CFG_RATE: rate_q8 = data[RATE_W-1:0];
			default: ;
		endcase
	endtask

	task automatic apply_config(phase_cfg_t c);
		write_reg(CFG_WIDTH, c.width_word);
		write_reg(CFG_HEIGHT, c.height_word);
		write_reg(CFG_THRESHOLD, c.thr_word);
		write_reg(CFG_RATE, c.rate_word);
		cfg_valid <= 1'b0;
	endtask

	// Holds the sender until every pending frame result is in, then idles
	// for a further drain period.
	task automatic settle();
		in_valid <= 1'b0;
		while (pending_frames.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic phase_cfg_t random_phase();
		phase_cfg_t c;
		c.width_word = ($urandom_range(0, 9) == 0) ? 16'h0000
			: {3'($urandom), 13'($urandom_range(1, 8))};
		c.height_word = 16'($urandom_range(0, 4));
		c.thr_word = ($urandom_range(0, 7) == 0) ? 16'($urandom_range(600, 1023))
			: 16'($urandom_range(0, 150));
		case ($urandom_range(0, 4))
			0: c.rate_word = 16'd7680;
			1: c.rate_word = 16'd256;
			2: c.rate_word = 16'd61440;
			3: c.rate_word = 16'd0;
			default: c.rate_word = 16'($urandom_range(256, 61440));
		endcase
		c.pixels = $urandom_range(8, 80);
		return c;
	endfunction

	initial begin
		phase_cfg_t corner[5];
		phase_cfg_t c;
		// One-pixel frames so every pixel closes a frame.
		directed_rows = '{
			'{'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
			'{'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1,
				'{32'd3, 10'd765, 8'd255, 8'd255, 8'd255, 1'b1, 16'd1, 32'd3, 32'd100,
				32'd3, 32'd100}},
			'{'{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00}, 1'b1,
				'{32'd4, 10'd765, 8'd255, 8'd255, 8'd255, 1'b0, 16'd1, 32'd3, 32'd100,
				32'd0, 32'd0}},
			'{'{8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80}, 1'b1,
				'{32'd5, 10'd0, 8'd128, 8'd128, 8'd128, 1'b0, 16'd1, 32'd3, 32'd100,
				32'd0, 32'd0}},
			'{'{8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55}, 1'b1,
				'{32'd6, 10'd255, 8'd170, 8'd85, 8'd170, 1'b1, 16'd2, 32'd6, 32'd200,
				32'd3, 32'd100}},
			'{'{8'h55, 8'hAA, 8'h55, 8'hAA, 8'h55, 8'hAA}, 1'b0, '0},
			'{'{8'h00, 8'hFF, 8'h00, 8'h01, 8'hFE, 8'h01}, 1'b0, '0},
			'{'{8'h3C, 8'h3C, 8'h3C, 8'h1F, 8'h1F, 8'h1F}, 1'b0, '0},
			'{'{8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00}, 1'b0, '0},
			'{'{8'h01, 8'h02, 8'h04, 8'h10, 8'h20, 8'h40}, 1'b0, '0},
			'{'{8'h80, 8'h40, 8'h20, 8'h08, 8'h04, 8'h02}, 1'b0, '0},
			'{'{8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00}, 1'b0, '0},
			'{'{8'hFE, 8'h7F, 8'h01, 8'h01, 8'h80, 8'hFE}, 1'b0, '0},
			'{'{8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF}, 1'b0, '0},
			'{'{8'h12, 8'h34, 8'h56, 8'h12, 8'h34, 8'h56}, 1'b0, '0}
		};
		// The oversize frame is left open after a few dozen pixels; the phase
		// after it keeps them open, and the first random phase shrinks the frame
		// below the count so it closes on the next pixel with saturated stats.
		corner = '{
			'{16'hE002, 16'h0000, 16'h0000, 16'h0000, 20},
			'{16'h0003, 16'h0002, 16'd765, 16'd256, 36},
			'{16'h0001, 16'h0001, 16'hFFFF, 16'hFFFF, 8},
			'{16'hFFFF, 16'h0000, 16'd30, 16'd61440, 40},
			'{16'h0001, 16'h1000, 16'd40, 16'd7680, 3}
		};
		reset_predictor();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		apply_config('{16'd1, 16'd1, 16'd60, 16'd7680, 0});
		foreach (directed_rows[i])
			send_pixel(directed_rows[i].pix, directed_rows[i].typed, directed_rows[i].want);
		foreach (corner[i]) begin
			settle();
			apply_config(corner[i]);
			repeat (corner[i].pixels) send_pixel(next_pixel(), 1'b0, '0);
		end
		while (random_pixels_sent < RANDOM_PIXELS) begin
			c = random_phase();
			settle();
			apply_config(c);
			repeat (c.pixels) begin
				send_pixel(next_pixel(), 1'b0, '0);
				random_pixels_sent++;
			end
		end
		settle();
		if (mismatch_count == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#(RUN_LIMIT_NS);
		$display("Verification failed");
		$finish;
	end

	// Receiver: free, choppy and held stretches of random length.
	always @(posedge clk) begin
		if (rx_left == 0) begin
			rx_mode <= rx_kind_t'($urandom_range(0, 2));
			rx_left <= $urandom_range(1, 60);
		end else begin
			rx_left <= rx_left - 1;
		end
		case (rx_mode)
			RX_FREE: out_stall <= 1'b0;
			RX_CHOPPY: out_stall <= 1'($urandom_range(0, 1));
			default: out_stall <= 1'b1;
		endcase
	end

	// ------------------------------------------------------------------
	// Checking
	// ------------------------------------------------------------------
	task automatic flag_mismatch(string msg);
		mismatch_count++;
		if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
	endtask

	task automatic compare_field(string name, logic [63:0] got, logic [63:0] want,
			logic [FRAME_W-1:0] idx);
		if (got !== want)
			flag_mismatch($sformatf("frame %0d %s: got %0d, expected %0d",
				idx, name, got, want));
	endtask

	// Both sides change only at the rising edge, so the falling edge sees
	// the beat that the next rising edge will take.
	always @(negedge clk) begin
		frame_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_frames.size() == 0) begin
				flag_mismatch($sformatf("result beat for frame %0d with none pending",
					frame_index));
			end else begin
				want = pending_frames.pop_front();
				compare_field("frame_index", frame_index, want.frame_index, want.frame_index);
				compare_field("motion_score", motion_score, want.motion_score,
					want.frame_index);
				compare_field("mean_red", mean_red, want.mean_red, want.frame_index);
				compare_field("mean_green", mean_green, want.mean_green, want.frame_index);
				compare_field("mean_blue", mean_blue, want.mean_blue, want.frame_index);
				compare_field("cut_found", cut_found, want.cut_found, want.frame_index);
				compare_field("shot_number", shot_number, want.shot_number, want.frame_index);
				compare_field("shot_start_frame", shot_start_frame, want.shot_start_frame,
					want.frame_index);
				compare_field("shot_start_ms", shot_start_ms, want.shot_start_ms,
					want.frame_index);
				compare_field("closed_shot_frames", closed_shot_frames,
					want.closed_shot_frames, want.frame_index);
				compare_field("closed_shot_ms", closed_shot_ms, want.closed_shot_ms,
					want.frame_index);
			end
		end
	end

endmodule
